@@ rtl/salru_pkg.sv @@
// Shared types and constants for the set-associative LRU cache lookup core.
// No dependencies; every other file but salru_req_if and salru_ram refers to this package by scoped names.
`timescale 1ns / 1ps

package salru_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 5;

   localparam int SET_CFG_WIDTH   = 4;
   localparam int WAYS_CFG_WIDTH  = 4;
   localparam int BLOCK_CFG_WIDTH = 5;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WAYS_IN_USE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_BITS  = 2'd2;

   localparam logic [SET_CFG_WIDTH-1:0]   SET_BITS_RESET    = 4'd4;
   localparam logic [WAYS_CFG_WIDTH-1:0]  WAYS_IN_USE_RESET = 4'd1;
   localparam logic [BLOCK_CFG_WIDTH-1:0] BLOCK_BITS_RESET  = 5'd4;

   localparam int OUTCOME_WIDTH = 2;
   localparam logic [OUTCOME_WIDTH-1:0] OUTCOME_HIT   = 2'd0;
   localparam logic [OUTCOME_WIDTH-1:0] OUTCOME_FILL  = 2'd1;
   localparam logic [OUTCOME_WIDTH-1:0] OUTCOME_EVICT = 2'd2;

   localparam int TOTAL_WIDTH = 32;

   typedef struct packed {
      logic clear;
      logic load;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic clear_last;
   } status_type;

endpackage

@@ rtl/salru_req_if.sv @@
// Request channel interface: one byte address per beat.
// Depends on nothing but its width parameter.
`timescale 1ns / 1ps

interface salru_req_if #(
   parameter int ADDR_WIDTH = 48
) ();
   logic                  valid;
   logic                  ready;
   logic [ADDR_WIDTH-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink (input valid, input address, output ready);
endinterface

@@ rtl/salru_rsp_if.sv @@
// Response channel interface: lookup outcome and running totals per beat.
// Uses widths from salru_pkg.
`timescale 1ns / 1ps

interface salru_rsp_if #(
   parameter int SET_IDX_WIDTH = 10,
   parameter int WAY_IDX_WIDTH = 3
) ();
   logic                                  valid;
   logic                                  ready;
   logic [salru_pkg::OUTCOME_WIDTH-1:0]   outcome;
   logic [SET_IDX_WIDTH-1:0]              line_set;
   logic [WAY_IDX_WIDTH-1:0]              way_used;
   logic [salru_pkg::TOTAL_WIDTH-1:0]     hit_total;
   logic [salru_pkg::TOTAL_WIDTH-1:0]     miss_total;
   logic [salru_pkg::TOTAL_WIDTH-1:0]     evict_total;

   modport source (output valid, output outcome, output line_set, output way_used,
                   output hit_total, output miss_total, output evict_total, input ready);
   modport sink (input valid, input outcome, input line_set, input way_used,
                 input hit_total, input miss_total, input evict_total, output ready);
endinterface

@@ rtl/salru_csr_if.sv @@
// Configuration write channel interface: register index and write data per beat.
// Uses widths from salru_pkg.
`timescale 1ns / 1ps

interface salru_csr_if ();
   logic                                  valid;
   logic                                  ready;
   logic [salru_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [salru_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/salru_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module salru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/salru_ctrl.sv @@
// Controller state machine: clearing pass after reset, then accept and lookup per item.
// Depends on salru_pkg for the command and status types.
`timescale 1ns / 1ps

module salru_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  salru_pkg::status_type status,
   output salru_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.clear  = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/salru_datapath.sv @@
// Datapath: configuration registers, address split, per-way line memories,
// parallel tag compare and LRU pick, write-back, totals and response register.
// Depends on salru_pkg and salru_ram.
`timescale 1ns / 1ps

module salru_datapath #(
   parameter int MAX_SET_BITS = 10,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 48,
   parameter int STAMP_WIDTH  = 32,
   parameter int WAY_BITS     = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  salru_pkg::cmd_type                    cmd,
   output salru_pkg::status_type                 status,
   input  logic [ADDR_WIDTH-1:0]                 req_address,
   input  logic                                  csr_we,
   input  logic [salru_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [salru_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [salru_pkg::OUTCOME_WIDTH-1:0]   rsp_outcome,
   output logic [MAX_SET_BITS-1:0]               rsp_line_set,
   output logic [WAY_BITS-1:0]                   rsp_way_used,
   output logic [salru_pkg::TOTAL_WIDTH-1:0]     rsp_hit_total,
   output logic [salru_pkg::TOTAL_WIDTH-1:0]     rsp_miss_total,
   output logic [salru_pkg::TOTAL_WIDTH-1:0]     rsp_evict_total
);

   localparam int SETS         = 2 ** MAX_SET_BITS;
   localparam int SB_BITS      = $clog2(MAX_SET_BITS + 1);
   localparam int WAY_CNT_BITS = $clog2(MAX_WAYS + 1);
   localparam int SHIFT_BITS   = $clog2(MAX_SET_BITS + 2 ** salru_pkg::BLOCK_CFG_WIDTH);
   localparam int LINE_WIDTH   = 1 + ADDR_WIDTH + STAMP_WIDTH;

   logic [salru_pkg::SET_CFG_WIDTH-1:0]   set_bits_ff, set_bits_in;
   logic [salru_pkg::WAYS_CFG_WIDTH-1:0]  ways_ff, ways_in;
   logic [salru_pkg::BLOCK_CFG_WIDTH-1:0] block_bits_ff, block_bits_in;

   logic [SB_BITS-1:0]      sb_eff;
   logic [WAY_CNT_BITS-1:0] ways_eff;
   logic [SHIFT_BITS-1:0]   tag_shift;
   logic [ADDR_WIDTH-1:0]   shifted_addr;
   logic [MAX_SET_BITS-1:0] set_mask;
   logic [MAX_SET_BITS-1:0] set_comb;
   logic [ADDR_WIDTH-1:0]   tag_comb;

   logic [MAX_SET_BITS-1:0] set_ff, set_in;
   logic [ADDR_WIDTH-1:0]   tag_ff, tag_in;
   logic [STAMP_WIDTH-1:0]  now_ff, now_in;
   logic [STAMP_WIDTH-1:0]  access_ff, access_in;
   logic [MAX_SET_BITS-1:0] clear_addr_ff, clear_addr_in;

   logic [LINE_WIDTH-1:0]   rd_line [MAX_WAYS];
   logic [MAX_WAYS-1:0]     line_valid;
   logic [ADDR_WIDTH-1:0]   line_tag [MAX_WAYS];
   logic [STAMP_WIDTH-1:0]  line_stamp [MAX_WAYS];

   logic [MAX_WAYS-1:0]     active;
   logic [MAX_WAYS-1:0]     stop;
   logic [MAX_WAYS-1:0]     beats;
   logic [WAY_BITS-1:0]     stop_way;
   logic [WAY_BITS-1:0]     old_way;
   logic [WAY_BITS-1:0]     chosen;
   logic [salru_pkg::OUTCOME_WIDTH-1:0] outcome;

   logic [MAX_WAYS-1:0]     way_we;
   logic [MAX_SET_BITS-1:0] wr_addr;
   logic [LINE_WIDTH-1:0]   wr_data;

   logic [salru_pkg::TOTAL_WIDTH-1:0] hits_ff, hits_in;
   logic [salru_pkg::TOTAL_WIDTH-1:0] misses_ff, misses_in;
   logic [salru_pkg::TOTAL_WIDTH-1:0] evicts_ff, evicts_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [salru_pkg::OUTCOME_WIDTH-1:0] outcome_ff, outcome_in;
   logic [MAX_SET_BITS-1:0]             set_out_ff, set_out_in;
   logic [WAY_BITS-1:0]                 way_out_ff, way_out_in;

   // Configuration writes are always accepted; unknown indexes are dropped.
   always_comb begin
      set_bits_in   = set_bits_ff;
      ways_in       = ways_ff;
      block_bits_in = block_bits_ff;
      if (csr_we) begin
         case (csr_index)
            salru_pkg::CSR_SET_BITS: begin
               set_bits_in = csr_data[salru_pkg::SET_CFG_WIDTH-1:0];
            end
            salru_pkg::CSR_WAYS_IN_USE: begin
               ways_in = csr_data[salru_pkg::WAYS_CFG_WIDTH-1:0];
            end
            salru_pkg::CSR_BLOCK_BITS: begin
               block_bits_in = csr_data[salru_pkg::BLOCK_CFG_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Saturate the set bit count and the way count to the built geometry; a way count of zero uses one way.
   always_comb begin
      if (int'(set_bits_ff) > MAX_SET_BITS) begin
         sb_eff = SB_BITS'(MAX_SET_BITS);
      end else begin
         sb_eff = SB_BITS'(set_bits_ff);
      end
      if (ways_ff == '0) begin
         ways_eff = WAY_CNT_BITS'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         ways_eff = WAY_CNT_BITS'(MAX_WAYS);
      end else begin
         ways_eff = WAY_CNT_BITS'(ways_ff);
      end
   end

   always_comb begin
      shifted_addr = req_address >> block_bits_ff;
      for (int i = 0; i < MAX_SET_BITS; i++) begin
         set_mask[i] = (i < int'(sb_eff));
      end
      set_comb  = shifted_addr[MAX_SET_BITS-1:0] & set_mask;
      tag_shift = SHIFT_BITS'(sb_eff) + SHIFT_BITS'(block_bits_ff);
      tag_comb  = req_address >> tag_shift;
   end

   always_comb begin
      set_in    = set_ff;
      tag_in    = tag_ff;
      now_in    = now_ff;
      access_in = access_ff;
      if (cmd.load) begin
         set_in    = set_comb;
         tag_in    = tag_comb;
         access_in = access_ff + 1'b1;
         now_in    = access_ff + 1'b1;
      end
   end

   assign clear_addr_in     = cmd.clear ? clear_addr_ff + 1'b1 : clear_addr_ff;
   assign status.clear_last = &clear_addr_ff;

   for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
      salru_ram #(
         .WIDTH (LINE_WIDTH),
         .DEPTH (SETS)
      ) u_line_ram (
         .clock   (clock),
         .wr_en   (way_we[w]),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (cmd.load),
         .rd_addr (set_comb),
         .rd_data (rd_line[w])
      );

      assign line_valid[w] = rd_line[w][LINE_WIDTH-1];
      assign line_tag[w]   = rd_line[w][STAMP_WIDTH +: ADDR_WIDTH];
      assign line_stamp[w] = rd_line[w][STAMP_WIDTH-1:0];
      assign way_we[w]     = cmd.clear || (cmd.commit && (chosen == WAY_BITS'(w)));
   end

   // A way stops the in-order scan when it is empty or holds the tag.
   // The LRU victim is the active way that beats every other active way:
   // a smaller stamp, or an equal stamp at a lower way.
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         active[w] = (w < int'(ways_eff));
         stop[w]   = active[w] && (!line_valid[w] || (line_tag[w] == tag_ff));
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         beats[i] = active[i];
         for (int j = 0; j < MAX_WAYS; j++) begin
            if ((j != i) && active[j] && !((line_stamp[i] < line_stamp[j]) ||
                ((line_stamp[i] == line_stamp[j]) && (i < j)))) begin
               beats[i] = 1'b0;
            end
         end
      end
      stop_way = '0;
      old_way  = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (stop[w]) begin
            stop_way = WAY_BITS'(w);
         end
         if (beats[w]) begin
            old_way = WAY_BITS'(w);
         end
      end
      if (|stop) begin
         chosen  = stop_way;
         outcome = line_valid[stop_way] ? salru_pkg::OUTCOME_HIT : salru_pkg::OUTCOME_FILL;
      end else begin
         chosen  = old_way;
         outcome = salru_pkg::OUTCOME_EVICT;
      end
   end

   assign wr_addr = cmd.clear ? clear_addr_ff : set_ff;
   assign wr_data = cmd.clear ? '0 : {1'b1, tag_ff, now_ff};

   always_comb begin
      hits_in    = hits_ff;
      misses_in  = misses_ff;
      evicts_in  = evicts_ff;
      outcome_in = outcome_ff;
      set_out_in = set_out_ff;
      way_out_in = way_out_ff;
      if (cmd.commit) begin
         outcome_in = outcome;
         set_out_in = set_ff;
         way_out_in = chosen;
         if (outcome == salru_pkg::OUTCOME_HIT) begin
            hits_in = hits_ff + 1'b1;
         end else begin
            misses_in = misses_ff + 1'b1;
         end
         if (outcome == salru_pkg::OUTCOME_EVICT) begin
            evicts_in = evicts_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= salru_pkg::SET_BITS_RESET;
         ways_ff       <= salru_pkg::WAYS_IN_USE_RESET;
         block_bits_ff <= salru_pkg::BLOCK_BITS_RESET;
         access_ff     <= '0;
         clear_addr_ff <= '0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         evicts_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         set_bits_ff   <= set_bits_in;
         ways_ff       <= ways_in;
         block_bits_ff <= block_bits_in;
         access_ff     <= access_in;
         clear_addr_ff <= clear_addr_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         evicts_ff     <= evicts_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff     <= set_in;
      tag_ff     <= tag_in;
      now_ff     <= now_in;
      outcome_ff <= outcome_in;
      set_out_ff <= set_out_in;
      way_out_ff <= way_out_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = outcome_ff;
   assign rsp_line_set    = set_out_ff;
   assign rsp_way_used    = way_out_ff;
   assign rsp_hit_total   = hits_ff;
   assign rsp_miss_total  = misses_ff;
   assign rsp_evict_total = evicts_ff;

endmodule

@@ rtl/set_assoc_cache_lru_lookup_core.sv @@
// Set-associative cache lookup with LRU replacement; top level of the block.
// The request address is registered together with the line RAM reads; the outcome then enters
// the response register once it is free, and the response beat stays valid while the response
// channel is stalled. No new request is taken until the last one is written back to the RAMs.
// Reset: a clearing pass zeroes every line of all 2**MAX_SET_BITS sets (1024 by default);
// no request beat is accepted during it, while configuration beats are taken at any time.
// Depends on salru_pkg, the channel interfaces, salru_ctrl and salru_datapath.
`timescale 1ns / 1ps

module set_assoc_cache_lru_lookup_core #(
   parameter int MAX_SET_BITS = 10,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 48,
   parameter int STAMP_WIDTH  = 32
) (
   input  logic         clock,
   input  logic         reset,
   salru_req_if.sink    req_bus,
   salru_rsp_if.source  rsp_bus,
   salru_csr_if.sink    csr_bus
);

   localparam int WAY_BITS = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

   salru_pkg::cmd_type    cmd;
   salru_pkg::status_type status;

   assign csr_bus.ready = 1'b1;

   salru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   salru_datapath #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_WIDTH   (ADDR_WIDTH),
      .STAMP_WIDTH  (STAMP_WIDTH),
      .WAY_BITS     (WAY_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_address     (req_bus.address),
      .csr_we          (csr_bus.valid),
      .csr_index       (csr_bus.index),
      .csr_data        (csr_bus.data),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_outcome     (rsp_bus.outcome),
      .rsp_line_set    (rsp_bus.line_set),
      .rsp_way_used    (rsp_bus.way_used),
      .rsp_hit_total   (rsp_bus.hit_total),
      .rsp_miss_total  (rsp_bus.miss_total),
      .rsp_evict_total (rsp_bus.evict_total)
   );

endmodule
